@@ hw/rtl/isms_pkg.sv @@
// Shared types, codes and the control store of the I2C master script sequencer.
package isms_pkg;

  localparam int SCRIPT_DEPTH_DEF = 256;
  localparam int PC_W             = 5;

  localparam logic [7:0] ST_MASK = 8'hF8;

  // Request types
  localparam logic [1:0] RT_LOAD   = 2'd0;
  localparam logic [1:0] RT_START  = 2'd1;
  localparam logic [1:0] RT_EVENT  = 2'd2;
  localparam logic [1:0] RT_SETTLE = 2'd3;

  // Engine modes
  localparam logic [1:0] MODE_FREE     = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_STOPPING = 2'd2;

  // Bus commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CONT  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // Masked bus status codes
  localparam logic [7:0] ST_START_SENT = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_ADDR_ACK_W = 8'h18;
  localparam logic [7:0] ST_ADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_ACK_W = 8'h28;
  localparam logic [7:0] ST_ADDR_ACK_R = 8'h40;
  localparam logic [7:0] ST_DATA_ACK_R = 8'h50;
  localparam logic [7:0] ST_DATA_NACK  = 8'h58;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] script_index;
    logic [7:0] script_byte;
    logic [7:0] script_length;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       start_refused;
    logic [1:0] engine_mode;
    logic [1:0] bus_cmd;
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       rx_store;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       done_res;
    logic [7:0] done_status;
  } res_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_FREE,
    U_INIT,
    U_FETCH,
    U_BEND_INIT,
    U_BEND_ADD,
    U_ADDR,
    U_REND_ADD,
    U_TXRD,
    U_TXLAST,
    U_DELIVER,
    U_STOP,
    U_REFUSE
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_BUSY,
    C_EVEN,
    C_BLK,
    C_SIZE,
    C_READ
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic            cmd_we;
    logic [1:0]      cmd;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic even;
    logic blk;
    logic size;
    logic read;
  } flags_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_RET    = 5'd0;
  localparam logic [PC_W-1:0] PC_LOAD   = 5'd1;
  localparam logic [PC_W-1:0] PC_SETTLE = 5'd2;
  localparam logic [PC_W-1:0] PC_START  = 5'd3;
  localparam logic [PC_W-1:0] PC_REFUSE = 5'd7;
  localparam logic [PC_W-1:0] PC_E08    = 5'd8;
  localparam logic [PC_W-1:0] PC_E18    = 5'd12;
  localparam logic [PC_W-1:0] PC_E28    = 5'd14;
  localparam logic [PC_W-1:0] PC_STOP   = 5'd16;
  localparam logic [PC_W-1:0] PC_CONT   = 5'd17;
  localparam logic [PC_W-1:0] PC_E50    = 5'd18;
  localparam logic [PC_W-1:0] PC_E58    = 5'd22;
  localparam logic [PC_W-1:0] PC_RESEND = 5'd25;
  localparam logic [PC_W-1:0] PC_OPEN   = 5'd26;

  function automatic uword_t uw(op_t op, logic cmd_we, logic [1:0] cmd, cond_t cond,
                                logic [PC_W-1:0] target, logic last);
    uword_t w;
    w.op     = op;
    w.cmd_we = cmd_we;
    w.cmd    = cmd;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = uw(U_NOP,       1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd1:    w = uw(U_LOAD,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd2:    w = uw(U_FREE,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd3:    w = uw(U_NOP,       1'b0, CMD_NONE,  C_BUSY,  PC_REFUSE, 1'b0);
      5'd4:    w = uw(U_INIT,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd5:    w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd6:    w = uw(U_BEND_INIT, 1'b1, CMD_START, C_NEVER, PC_RET,    1'b1);
      5'd7:    w = uw(U_REFUSE,    1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd8:    w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd9:    w = uw(U_ADDR,      1'b1, CMD_CONT,  C_EVEN,  PC_RET,    1'b0);
      5'd10:   w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd11:   w = uw(U_REND_ADD,  1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd12:   w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd13:   w = uw(U_TXRD,      1'b1, CMD_CONT,  C_NEVER, PC_RET,    1'b1);
      5'd14:   w = uw(U_NOP,       1'b0, CMD_NONE,  C_BLK,   PC_E18,    1'b0);
      5'd15:   w = uw(U_NOP,       1'b0, CMD_NONE,  C_SIZE,  PC_OPEN,   1'b0);
      5'd16:   w = uw(U_STOP,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd17:   w = uw(U_NOP,       1'b1, CMD_CONT,  C_NEVER, PC_RET,    1'b1);
      5'd18:   w = uw(U_DELIVER,   1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd19:   w = uw(U_NOP,       1'b0, CMD_NONE,  C_READ,  PC_CONT,   1'b0);
      5'd20:   w = uw(U_NOP,       1'b0, CMD_NONE,  C_SIZE,  PC_OPEN,   1'b0);
      5'd21:   w = uw(U_STOP,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd22:   w = uw(U_DELIVER,   1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd23:   w = uw(U_NOP,       1'b0, CMD_NONE,  C_READ,  PC_RESEND, 1'b0);
      5'd24:   w = uw(U_STOP,      1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      5'd25:   w = uw(U_TXLAST,    1'b1, CMD_START, C_NEVER, PC_RET,    1'b1);
      5'd26:   w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd27:   w = uw(U_BEND_ADD,  1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd28:   w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd29:   w = uw(U_ADDR,      1'b1, CMD_START, C_EVEN,  PC_RET,    1'b0);
      5'd30:   w = uw(U_FETCH,     1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b0);
      5'd31:   w = uw(U_REND_ADD,  1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
      default: w = uw(U_NOP,       1'b0, CMD_NONE,  C_NEVER, PC_RET,    1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry(logic [1:0] req_type, logic [7:0] bus_status);
    logic [PC_W-1:0] pc;
    logic [7:0]      st;
    st = bus_status & ST_MASK;
    unique case (req_type)
      RT_LOAD:   pc = PC_LOAD;
      RT_START:  pc = PC_START;
      RT_SETTLE: pc = PC_SETTLE;
      default: begin
        case (st) inside
          ST_START_SENT:               pc = PC_E08;
          ST_ADDR_ACK_W:               pc = PC_E18;
          ST_ADDR_NACK, ST_DATA_ACK_W: pc = PC_E28;
          ST_RESTART, ST_ADDR_ACK_R:   pc = PC_CONT;
          ST_DATA_ACK_R:               pc = PC_E50;
          ST_DATA_NACK:                pc = PC_E58;
          default:                     pc = PC_STOP;
        endcase
      end
    endcase
    return pc;
  endfunction

endpackage

@@ hw/rtl/i2c_master_script_sequencer.sv @@
// Top level of the I2C master script sequencer: handshakes, step counter, result register.
//
//   channel   signals                       payload
//   request   req_valid, req_stall, req     req_t: load / start / bus status / settle
//   result    res_valid, res_stall, res     res_t: command, tx byte, rx byte, done
//
// A request is accepted and then runs its control words in turn; how many it runs
// is set by the single script store read port (one script byte
// per fetch word, with a registered read) and by branching on those bytes.
// Reset clears the positions, frees the engine and stalls requests; the store is not cleared.
// The next request is taken as soon as the result is in the output register;
// a stalled output holds only the final control word of the following request.
module i2c_master_script_sequencer
  import isms_pkg::*;
#(
  parameter int SCRIPT_DEPTH = SCRIPT_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic            busy;
  logic [PC_W-1:0] pc;
  req_t            req_q;
  uword_t          ctrl;
  flags_t          flags;
  res_t            res_next;
  logic            accept;
  logic            hold;
  logic            step;
  logic            hit;

  assign req_stall = busy || rst;
  assign accept    = req_valid && !req_stall;
  assign ctrl      = ucode(pc);
  // Hold the final word while the previous result is still unread.
  assign hold      = ctrl.last && res_valid && res_stall;
  assign step      = busy && !hold;

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER: hit = 1'b0;
      C_BUSY:  hit = flags.busy;
      C_EVEN:  hit = flags.even;
      C_BLK:   hit = flags.blk;
      C_SIZE:  hit = flags.size;
      C_READ:  hit = flags.read;
      default: hit = 1'b0;
    endcase
  end

  isms_datapath #(
    .SCRIPT_DEPTH(SCRIPT_DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .clear   (accept),
    .ctrl    (ctrl),
    .req     (req_q),
    .flags   (flags),
    .res_next(res_next)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (step && ctrl.last) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= PC_RET;
      res_valid <= 1'b0;
    end else begin
      if (step && ctrl.last) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= entry(req.req_type, req.bus_status);
      end else if (step) begin
        if (ctrl.last) begin
          busy <= 1'b0;
        end else if (hit) begin
          pc <= ctrl.target;
        end else begin
          pc <= pc + 5'd1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/isms_datapath.sv @@
// Script store, position registers and result assembly driven by one control word.
module isms_datapath
  import isms_pkg::*;
#(
  parameter int SCRIPT_DEPTH = SCRIPT_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   clear,
  input  uword_t ctrl,
  input  req_t   req,
  output flags_t flags,
  output res_t   res_next
);

  localparam int AW = $clog2(SCRIPT_DEPTH);

  logic [7:0] mem [SCRIPT_DEPTH];
  logic [7:0] rd;

  logic [7:0] script_pos, script_pos_next;
  logic [7:0] script_size, script_size_next;
  logic [7:0] block_end, block_end_next;
  logic [7:0] read_pos, read_pos_next;
  logic [7:0] read_end, read_end_next;
  logic [7:0] last_address, last_address_next;
  logic [1:0] engine_state, engine_state_next;
  res_t       work;

  // Reduce an 8-bit position into the store's range.
  function automatic logic [AW-1:0] wrap(logic [7:0] v);
    logic [11:0] r;
    r = {4'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (12'(SCRIPT_DEPTH) << k)) begin
        r = r - (12'(SCRIPT_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  assign flags.busy = (engine_state != MODE_FREE);
  assign flags.even = ~rd[0];
  assign flags.blk  = (script_pos < block_end);
  assign flags.size = (script_pos < script_size);
  assign flags.read = (read_pos < read_end);

  always_comb begin
    script_pos_next   = script_pos;
    script_size_next  = script_size;
    block_end_next    = block_end;
    read_pos_next     = read_pos;
    read_end_next     = read_end;
    last_address_next = last_address;
    engine_state_next = engine_state;
    res_next          = work;
    if (ctrl.cmd_we) begin
      res_next.bus_cmd = ctrl.cmd;
    end
    case (ctrl.op)
      U_FREE: engine_state_next = MODE_FREE;
      U_INIT: begin
        engine_state_next = MODE_RUNNING;
        script_pos_next   = 8'd0;
        script_size_next  = req.script_length;
        read_pos_next     = 8'd0;
        read_end_next     = 8'd0;
      end
      U_FETCH:     script_pos_next = script_pos + 8'd1;
      U_BEND_INIT: block_end_next = rd + 8'd1;
      U_BEND_ADD:  block_end_next = block_end + rd + 8'd1;
      U_ADDR: begin
        last_address_next = rd;
        res_next.tx_load  = 1'b1;
        res_next.tx_byte  = rd;
      end
      U_REND_ADD: read_end_next = read_end + rd;
      U_TXRD: begin
        res_next.tx_load = 1'b1;
        res_next.tx_byte = rd;
      end
      U_TXLAST: begin
        res_next.tx_load = 1'b1;
        res_next.tx_byte = last_address;
      end
      U_DELIVER: begin
        res_next.rx_store = 1'b1;
        res_next.rx_index = read_pos;
        res_next.rx_data  = req.rx_byte;
        read_pos_next     = read_pos + 8'd1;
      end
      U_STOP: begin
        engine_state_next    = MODE_STOPPING;
        res_next.bus_cmd     = CMD_STOP;
        res_next.done_res    = 1'b1;
        res_next.done_status = req.bus_status & ST_MASK;
      end
      U_REFUSE: res_next.start_refused = 1'b1;
      default: ;
    endcase
    res_next.engine_mode = engine_state_next;
  end

  always_ff @(posedge clk) begin
    if (step && ctrl.op == U_LOAD) begin
      mem[wrap(req.script_index)] <= req.script_byte;
    end
    if (step && ctrl.op == U_FETCH) begin
      rd <= mem[wrap(script_pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      work <= '0;
    end else if (step) begin
      work <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      script_pos   <= 8'd0;
      script_size  <= 8'd0;
      block_end    <= 8'd0;
      read_pos     <= 8'd0;
      read_end     <= 8'd0;
      last_address <= 8'd0;
      engine_state <= MODE_FREE;
    end else if (step) begin
      script_pos   <= script_pos_next;
      script_size  <= script_size_next;
      block_end    <= block_end_next;
      read_pos     <= read_pos_next;
      read_end     <= read_end_next;
      last_address <= last_address_next;
      engine_state <= engine_state_next;
    end
  end

endmodule

@@ verif/tb_i2c_master_script_sequencer.sv @@
// Self-checking testbench for the I2C master script sequencer.
`timescale 1ns / 100ps

module tb_i2c_master_script_sequencer;
  import isms_pkg::*;

  localparam int N_ITEMS   = 1200;
  localparam int MAX_CYCLE = 500_000;

  typedef enum logic [1:0] {WANT_SCRIPT, WANT_EVENT, WANT_SETTLE} next_t;

  typedef struct {
    req_t q;
    bit   typed;
    res_t want;
  } step_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  i2c_master_script_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sequencer state as predicted
  logic [7:0] sq_store [256];
  logic [7:0] sq_pos, sq_size, sq_bend, sq_rpos, sq_rend, sq_addr;
  logic [1:0] sq_mode;

  res_t  pending_cmds [$];
  int    fails     = 0;
  int    n_sent    = 0;
  int    idle_pct  = 25;
  int    stall_pct = 53;
  int    cycles    = 0;
  next_t nx_kind   = WANT_SCRIPT;
  logic [7:0] nx_st = ST_START_SENT;
  logic  rd_odd     = 1'b0;

  function automatic req_t rq(logic [1:0] t, logic [7:0] idx, logic [7:0] byt,
                              logic [7:0] len, logic [7:0] st, logic [7:0] rx);
    req_t q;
    q.req_type      = t;
    q.script_index  = idx;
    q.script_byte   = byt;
    q.script_length = len;
    q.bus_status    = st;
    q.rx_byte       = rx;
    return q;
  endfunction

  function automatic res_t rs(logic refused, logic [1:0] mode, logic [1:0] cmd,
                              logic done, logic [7:0] st);
    res_t r;
    r               = '0;
    r.start_refused = refused;
    r.engine_mode   = mode;
    r.bus_cmd       = cmd;
    r.done_res      = done;
    r.done_status   = st;
    return r;
  endfunction

  function automatic logic [7:0] fetch_byte();
    logic [7:0] v;
    v      = sq_store[sq_pos];
    sq_pos = sq_pos + 8'd1;
    return v;
  endfunction

  function automatic void send_addr(inout res_t o);
    sq_addr   = fetch_byte();
    o.tx_load = 1'b1;
    o.tx_byte = sq_addr;
    if (sq_addr[0]) sq_rend = sq_rend + fetch_byte();
  endfunction

  function automatic void open_next(inout res_t o);
    sq_bend = sq_bend + fetch_byte() + 8'd1;
    send_addr(o);
    o.bus_cmd = CMD_START;
  endfunction

  function automatic void halt(inout res_t o, input logic [7:0] st);
    o.bus_cmd     = CMD_STOP;
    sq_mode       = MODE_STOPPING;
    o.done_res    = 1'b1;
    o.done_status = st;
  endfunction

  function automatic void take_rx(inout res_t o, input logic [7:0] rx);
    o.rx_store = 1'b1;
    o.rx_index = sq_rpos;
    o.rx_data  = rx;
    sq_rpos    = sq_rpos + 8'd1;
  endfunction

  function automatic res_t sequencer_step(req_t q);
    res_t       o;
    logic [7:0] st;
    o  = '0;
    st = q.bus_status & ST_MASK;
    case (q.req_type)
      RT_LOAD: sq_store[q.script_index] = q.script_byte;
      RT_START: begin
        if (sq_mode != MODE_FREE) begin
          o.start_refused = 1'b1;
        end else begin
          sq_mode   = MODE_RUNNING;
          sq_pos    = 8'd0;
          sq_size   = q.script_length;
          sq_rpos   = 8'd0;
          sq_rend   = 8'd0;
          sq_bend   = fetch_byte() + 8'd1;
          o.bus_cmd = CMD_START;
        end
      end
      RT_EVENT: begin
        case (st)
          ST_START_SENT: begin
            send_addr(o);
            o.bus_cmd = CMD_CONT;
          end
          ST_ADDR_ACK_W: begin
            o.tx_load = 1'b1;
            o.tx_byte = fetch_byte();
            o.bus_cmd = CMD_CONT;
          end
          ST_ADDR_NACK, ST_DATA_ACK_W: begin
            if (sq_pos < sq_bend) begin
              o.tx_load = 1'b1;
              o.tx_byte = fetch_byte();
              o.bus_cmd = CMD_CONT;
            end else if (sq_pos < sq_size) begin
              open_next(o);
            end else begin
              halt(o, st);
            end
          end
          ST_RESTART, ST_ADDR_ACK_R: o.bus_cmd = CMD_CONT;
          ST_DATA_ACK_R: begin
            take_rx(o, q.rx_byte);
            if (sq_rpos < sq_rend) o.bus_cmd = CMD_CONT;
            else if (sq_pos < sq_size) open_next(o);
            else halt(o, st);
          end
          ST_DATA_NACK: begin
            take_rx(o, q.rx_byte);
            if (sq_rpos < sq_rend) begin
              o.tx_load = 1'b1;
              o.tx_byte = sq_addr;
              o.bus_cmd = CMD_START;
            end else begin
              halt(o, st);
            end
          end
          default: halt(o, st);
        endcase
      end
      default: sq_mode = MODE_FREE;
    endcase
    o.engine_mode = sq_mode;
    return o;
  endfunction

  // Pick the status a well-behaved bus controller would report next
  function automatic void plan_next(req_t q, res_t r);
    logic [7:0] st;
    st = q.bus_status & ST_MASK;
    case (q.req_type)
      RT_START: begin
        if (r.start_refused) begin
          nx_kind = WANT_SETTLE;
        end else begin
          nx_kind = WANT_EVENT;
          nx_st   = ST_START_SENT;
        end
      end
      RT_SETTLE: nx_kind = WANT_SCRIPT;
      RT_EVENT: begin
        if (r.bus_cmd == CMD_STOP) begin
          nx_kind = WANT_SETTLE;
        end else if (r.bus_cmd == CMD_START) begin
          rd_odd = r.tx_byte[0];
          nx_st  = ST_RESTART;
        end else if (st == ST_START_SENT || st == ST_RESTART) begin
          if (st == ST_START_SENT) rd_odd = r.tx_byte[0];
          nx_st = rd_odd ? ST_ADDR_ACK_R : ST_ADDR_ACK_W;
        end else if (st == ST_ADDR_ACK_W || st == ST_DATA_ACK_W || st == ST_ADDR_NACK) begin
          nx_st = ($urandom_range(9) == 0) ? ST_ADDR_NACK : ST_DATA_ACK_W;
        end else if (sq_rpos + 8'd1 >= sq_rend) begin
          nx_st = $urandom_range(1) ? ST_DATA_NACK : ST_DATA_ACK_R;
        end else begin
          nx_st = ($urandom_range(9) == 0) ? ST_DATA_NACK : ST_DATA_ACK_R;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send(input req_t q, input bit typed, input res_t want);
    res_t r;
    r = sequencer_step(q);
    pending_cmds.push_back(typed ? want : r);
    plan_next(q, r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    n_sent++;
    if (n_sent < 400) begin
      idle_pct  = 25;
      stall_pct = 53;
    end else if (n_sent < 800) begin
      idle_pct  = 53;
      stall_pct = 25;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
  endtask

  // Hold off the sender until every expected command has come back
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic chk(string nm, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", nm, e, a);
      fails++;
    end
  endtask

  always @(negedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    res_t due;
    if (!rst && res_valid && !res_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("result with no request waiting: %h", res);
        fails++;
      end else begin
        due = pending_cmds.pop_front();
        chk("start_refused", 8'(due.start_refused), 8'(res.start_refused));
        chk("engine_mode", 8'(due.engine_mode), 8'(res.engine_mode));
        chk("bus_cmd", 8'(due.bus_cmd), 8'(res.bus_cmd));
        chk("tx_load", 8'(due.tx_load), 8'(res.tx_load));
        chk("tx_byte", due.tx_byte, res.tx_byte);
        chk("rx_store", 8'(due.rx_store), 8'(res.rx_store));
        chk("rx_index", due.rx_index, res.rx_index);
        chk("rx_data", due.rx_data, res.rx_data);
        chk("done_res", 8'(due.done_res), 8'(res.done_res));
        chk("done_status", due.done_status, res.done_status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("i2c_master_script_sequencer regression: fail");
      $finish;
    end
  end

  initial begin
    step_row_t  steps [$];
    logic [7:0] script [$];
    logic [7:0] adr, len, st;
    int         nblk, cnt;

    sq_pos  = '0;
    sq_size = '0;
    sq_bend = '0;
    sq_rpos = '0;
    sq_rend = '0;
    sq_addr = '0;
    sq_mode = MODE_FREE;

    // Two blocks: write A0 with 00 and FF, then read two bytes from A1
    steps.push_back(step_row_t'{rq(RT_SETTLE, 0, 0, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 0, 8'd3, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 1, 8'hA0, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 2, 8'h00, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 3, 8'hFF, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 4, 8'd2, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 5, 8'hA1, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 6, 8'd2, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_START, 0, 0, 8'd7, 0, 0), 1'b1,
                                rs(1'b0, MODE_RUNNING, CMD_START, 1'b0, 8'h00)});
    steps.push_back(step_row_t'{rq(RT_START, 0, 0, 8'hFF, 0, 0), 1'b1,
                                rs(1'b1, MODE_RUNNING, CMD_NONE, 1'b0, 8'h00)});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, 8'h0F, 0), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_ADDR_ACK_W, 0), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_DATA_ACK_W, 0), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, 8'h2B, 0), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_RESTART, 0), 1'b1,
                                rs(1'b0, MODE_RUNNING, CMD_CONT, 1'b0, 8'h00)});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, 8'h47, 0), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_DATA_ACK_R, 8'h00), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_DATA_NACK, 8'hFF), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_DATA_ACK_R, 8'h5A), 1'b0, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, 8'hFF, 8'hFF), 1'b1,
                                rs(1'b0, MODE_STOPPING, CMD_STOP, 1'b1, 8'hF8)});
    steps.push_back(step_row_t'{rq(RT_LOAD, 8'd128, 8'h80, 0, 0, 0), 1'b1,
                                rs(1'b0, MODE_STOPPING, CMD_NONE, 1'b0, 8'h00)});
    steps.push_back(step_row_t'{rq(RT_START, 0, 0, 8'h00, 0, 0), 1'b1,
                                rs(1'b1, MODE_STOPPING, CMD_NONE, 1'b0, 8'h00)});
    steps.push_back(step_row_t'{rq(RT_SETTLE, 0, 0, 0, 0, 0), 1'b1, '0});
    steps.push_back(step_row_t'{rq(RT_EVENT, 0, 0, 0, ST_ADDR_NACK, 0), 1'b1,
                                rs(1'b0, MODE_STOPPING, CMD_STOP, 1'b1, ST_ADDR_NACK)});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) send(steps[i].q, steps[i].typed, steps[i].want);
    drain();

    // Fill the whole store so that no stray fetch reads an unwritten entry
    for (int i = 0; i < 256; i++) begin
      send(rq(RT_LOAD, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)),
           1'b0, '0);
    end

    nx_kind = WANT_SETTLE;
    while (n_sent < N_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        send(rq(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom)),
             1'b0, '0);
      end else begin
        case (nx_kind)
          WANT_SCRIPT: begin
            if ($urandom_range(4) == 0) drain();
            script.delete();
            nblk = $urandom_range(1, 3);
            for (int b = 0; b < nblk; b++) begin
              adr = 8'($urandom);
              if (adr[0]) begin
                cnt = ($urandom_range(19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
                script.push_back(8'd2);
                script.push_back(adr);
                script.push_back(cnt[7:0]);
              end else begin
                cnt = $urandom_range(1, 4);
                script.push_back(cnt[7:0] + 8'd1);
                script.push_back(adr);
                repeat (cnt) script.push_back(8'($urandom));
              end
            end
            foreach (script[i]) begin
              send(rq(RT_LOAD, i[7:0], script[i], 8'($urandom), 8'($urandom), 8'($urandom)),
                   1'b0, '0);
            end
            len = ($urandom_range(6) == 0) ? 8'($urandom) : 8'(script.size());
            send(rq(RT_START, 8'($urandom), 8'($urandom), len, 8'($urandom), 8'($urandom)),
                 1'b0, '0);
          end
          WANT_SETTLE: begin
            send(rq(RT_SETTLE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom)),
                 1'b0, '0);
          end
          default: begin
            st = nx_st | 8'($urandom_range(7));
            send(rq(RT_EVENT, 8'($urandom), 8'($urandom), 8'($urandom), st, 8'($urandom)),
                 1'b0, '0);
          end
        endcase
      end
    end

    drain();
    repeat (24) @(posedge clk);
    if (pending_cmds.size() != 0) fails++;
    if (fails == 0) begin
      $display("i2c_master_script_sequencer regression: pass");
    end else begin
      $display("i2c_master_script_sequencer regression: fail");
    end
    $finish;
  end

endmodule
